FILE: hw/rtl/plir_pkg.sv
// ----------------------------------------------------------------------------
// plir_pkg - shared types for the positional list
// Operation codes and the per-cycle control word broadcast along the cell row.
// ----------------------------------------------------------------------------
package plir_pkg;

  // Wide enough for any cell index or list position up to 1024 entries
  localparam int TGT_W = 11;

  typedef enum logic [2:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_BACK  = 3'd1,
    OP_INSERT_AT = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_READ_AT   = 3'd6
  } op_t;

  // Shift command seen by every cell
  typedef struct packed {
    logic             ins;  // open a gap at tgt, write new word there
    logic             rem;  // close the gap at tgt
    logic [TGT_W-1:0] tgt;
  } cell_ctl_t;

  // Decoded operation
  typedef struct packed {
    cell_ctl_t shift;
    logic      ok;   // operation is legal in the current state
    logic      rd;   // operation is a read
  } ctl_t;

endpackage

FILE: hw/rtl/plir_cell.sv
// ----------------------------------------------------------------------------
// plir_cell - one storage cell of the list
// Holds, takes its left neighbour, its right neighbour or the new word.
// ----------------------------------------------------------------------------
module plir_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  plir_pkg::cell_ctl_t   ctl,
  input  logic [DATA_WIDTH-1:0] new_val,
  input  logic [DATA_WIDTH-1:0] left_val,
  input  logic [DATA_WIDTH-1:0] right_val,
  output logic [DATA_WIDTH-1:0] val
);
  import plir_pkg::*;

  localparam logic [TGT_W-1:0] MY_IDX = TGT_W'(IDX);

  logic [DATA_WIDTH-1:0] val_r;
  logic [DATA_WIDTH-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (MY_IDX == ctl.tgt) begin
        val_nxt = new_val;
      end else if (MY_IDX > ctl.tgt) begin
        val_nxt = left_val;
      end
    end else if (ctl.rem && (MY_IDX >= ctl.tgt)) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

FILE: hw/rtl/plir_ctrl.sv
// ----------------------------------------------------------------------------
// plir_ctrl - operation decode and fill count
// Checks each operation against the fill level and picks the shift point.
// ----------------------------------------------------------------------------
module plir_ctrl #(
  parameter int CAPACITY = 16,
  localparam int FW      = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  plir_pkg::op_t     op,
  input  logic [4:0]        position,
  output plir_pkg::ctl_t    ctl,
  output logic [FW-1:0]     fill_after
);
  import plir_pkg::*;

  logic [FW-1:0]    fill_r;
  logic [FW-1:0]    fill_nxt;
  logic [TGT_W-1:0] f_t;
  logic [TGT_W-1:0] p_t;
  logic             full;
  logic             empty;
  logic             is_ins;
  logic             is_rem;
  logic             ok;
  logic [TGT_W-1:0] tgt;

  assign f_t   = TGT_W'(fill_r);
  assign p_t   = TGT_W'(position);
  assign full  = (f_t == TGT_W'(CAPACITY));
  assign empty = (fill_r == '0);

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    ok     = 1'b0;
    tgt    = '0;
    unique case (op)
      OP_ADD_FRONT: begin
        is_ins = 1'b1;
        ok     = !full;
      end
      OP_ADD_BACK: begin
        is_ins = 1'b1;
        ok     = !full;
        tgt    = f_t;
      end
      OP_INSERT_AT: begin
        is_ins = 1'b1;
        ok     = !full && (p_t <= f_t);
        tgt    = p_t;
      end
      OP_REM_FRONT: begin
        is_rem = 1'b1;
        ok     = !empty;
      end
      OP_REM_BACK: begin
        is_rem = 1'b1;
        ok     = !empty;
        tgt    = f_t - TGT_W'(1);
      end
      OP_REM_AT: begin
        is_rem = 1'b1;
        ok     = (p_t < f_t);
        tgt    = p_t;
      end
      OP_READ_AT: begin
        ok  = (p_t < f_t);
        tgt = p_t;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ok && is_ins) begin
      fill_nxt = fill_r + FW'(1);
    end else if (ok && is_rem) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  // Cells only move on an accepted, legal word
  assign ctl.shift.ins = fire && ok && is_ins;
  assign ctl.shift.rem = fire && ok && is_rem;
  assign ctl.shift.tgt = tgt;
  assign ctl.ok        = ok;
  assign ctl.rd        = (op == OP_READ_AT);
  assign fill_after    = fill_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (fire) begin
      fill_r <= fill_nxt;
    end
  end

endmodule

FILE: hw/rtl/positional_list_insert_remove.sv
// ----------------------------------------------------------------------------
// positional_list_insert_remove - bounded list with positional insert/remove
// Row of shifting cells holding an ordered list, head in cell 0.
// ----------------------------------------------------------------------------
// Each input word is one operation: add at front or back, insert at a
// position, remove at front, back or a position, or read at a position.
// Every word yields exactly one result word in the next cycle, carrying a
// success flag, the read data (zero unless an accepted read) and the count
// held after the operation (modulo 32). The list lives in a row of CAPACITY
// cells; an insert makes every cell behind the position take its left
// neighbour and a removal makes every cell from the position take its right
// neighbour, all in the same cycle, so one operation completes per clock and
// a new word is taken every cycle while the result register is free or being
// drained. Positions are 5 bits wide, so only the first 32 cells can be named
// by insert, remove-at or read. Illegal operations (full list, empty list,
// position out of range, unused code) leave the list untouched and report
// a zero flag. Cell contents need no clearing after reset.
// ----------------------------------------------------------------------------
module positional_list_insert_remove #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] op, [7:3] position, [39:8] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [0] accepted, [32:1] read_value,
                                  // [37:33] count, [39:38] zero
);
  import plir_pkg::*;

  localparam int FW   = $clog2(CAPACITY + 1);
  localparam int EW   = (FW > 5) ? FW : 5;
  // Cells that a 5-bit position can reach
  localparam int RD_N = (CAPACITY < 32) ? CAPACITY : 32;

  // Input word fields
  op_t         in_op;
  logic [4:0]  in_position;
  logic [31:0] in_value;

  assign in_op       = op_t'(in_tdata[2:0]);
  assign in_position = in_tdata[7:3];
  assign in_value    = in_tdata[39:8];

  logic fire;
  assign fire = in_tvalid && in_tready;

  // Decode and fill count
  ctl_t          ctl;
  logic [FW-1:0] fill_after;
  logic [EW-1:0] fill_ext;

  plir_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .op         (in_op),
    .position   (in_position),
    .ctl        (ctl),
    .fill_after (fill_after)
  );

  assign fill_ext = EW'(fill_after);

  // Word to store: low DATA_WIDTH bits of the value, zero-extended if wider
  logic [DATA_WIDTH-1:0] store_val;

  generate
    if (DATA_WIDTH <= 32) begin : g_store_narrow
      assign store_val = in_value[DATA_WIDTH-1:0];
    end else begin : g_store_wide
      assign store_val = {{(DATA_WIDTH-32){1'b0}}, in_value};
    end
  endgenerate

  // Cell row
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_v;
      logic [DATA_WIDTH-1:0] right_v;

      if (i == 0) begin : g_head
        assign left_v = store_val;   // never selected: nothing lies before the head
      end else begin : g_mid_l
        assign left_v = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign right_v = cell_q[i];  // vacated slot, contents do not matter
      end else begin : g_mid_r
        assign right_v = cell_q[i+1];
      end

      plir_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .IDX        (i)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl.shift),
        .new_val   (store_val),
        .left_val  (left_v),
        .right_val (right_v),
        .val       (cell_q[i])
      );
    end
  endgenerate

  // Read select over the addressable cells
  logic [DATA_WIDTH-1:0] rd_word;
  logic [31:0]           rd_ext;
  logic [31:0]           rd_res;

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (in_position == 5'(i)) begin
        rd_word = cell_q[i];
      end
    end
  end

  generate
    if (DATA_WIDTH >= 32) begin : g_rd_trunc
      assign rd_ext = rd_word[31:0];
    end else begin : g_rd_sext
      assign rd_ext = {{(32-DATA_WIDTH){rd_word[DATA_WIDTH-1]}}, rd_word};
    end
  endgenerate

  assign rd_res = (ctl.ok && ctl.rd) ? rd_ext : '0;

  // Result register
  logic        out_valid_r;
  logic        out_accepted_r;
  logic [31:0] out_read_value_r;
  logic [4:0]  out_count_r;

  assign in_tready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_accepted_r   <= ctl.ok;
      out_read_value_r <= rd_res;
      out_count_r      <= fill_ext[4:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_count_r, out_read_value_r, out_accepted_r};

  // Checks
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("accepted word produced no result");

  a_one_shift_kind: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.shift.ins, ctl.shift.rem}))
    else $error("insert and remove issued together");

  a_reject_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_accepted_r) |-> (out_read_value_r == '0))
    else $error("rejected operation returned read data");

  a_shift_only_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.shift.ins || ctl.shift.rem) |-> (fire && ctl.ok))
    else $error("cells shifted on an illegal or unaccepted word");

endmodule

FILE: bench/tb_positional_list_insert_remove.sv
// ----------------------------------------------------------------------------
// tb_positional_list_insert_remove - self-checking bench for the positional list
// Feeds list operations over the input stream, predicts each result word from
// a local copy of the list and checks every returned word field by field.
// ----------------------------------------------------------------------------
// A short directed run covers the empty list, out-of-range positions, append
// at the tail, the unused op code and extreme values. The random run then
// alternates grow, shrink and read-heavy phases so the list often hits both
// empty and full, with a share of noise words (any op, any position). Both
// stream sides idle at random, with quiet stretches of back-to-back traffic,
// and the sender stops at least once until every result is back.
// ----------------------------------------------------------------------------
module tb_positional_list_insert_remove;
  import plir_pkg::*;

  localparam int          LIST_DEPTH = 16;
  localparam int          N_WORDS    = 1000;     // random words after the directed set
  localparam int          CYC_LIMIT  = 500000;
  localparam int          TAIL_WAIT  = 8;        // margin after the last result
  localparam logic [2:0]  OP_UNUSED  = 3'd7;

  // Phase of the random run
  typedef enum logic [1:0] {
    PH_GROW,
    PH_SHRINK,
    PH_MIXED
  } phase_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  pos;
    logic [31:0] val;
  } list_cmd_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] read_value;
    logic [4:0]  count;
  } list_rsp_t;

  typedef struct {
    list_cmd_t cmd;
    int        gap;    // idle cycles before the word is offered
    bit        drain;  // hold the word back until every result is in
  } pend_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [2:0] op, [7:3] position, [39:8] value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [0] accepted, [32:1] read_value, [37:33] count

  always #10 clk = ~clk;

  positional_list_insert_remove #(
    .CAPACITY   (LIST_DEPTH),
    .DATA_WIDTH (32)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // --------------------------------------------------------------------------
  // Predictor: local copy of the list, head in slot 0
  // --------------------------------------------------------------------------
  logic [31:0] list_mem [LIST_DEPTH];
  int          list_len = 0;

  function automatic bit list_insert(int pos, logic [31:0] val);
    if (list_len >= LIST_DEPTH || pos > list_len) return 1'b0;
    for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
    list_mem[pos] = val;
    list_len++;
    return 1'b1;
  endfunction

  function automatic bit list_remove(int pos);
    if (list_len == 0 || pos >= list_len) return 1'b0;
    for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
    return 1'b1;
  endfunction

  // Apply one word to the local list and return the result it should give
  function automatic list_rsp_t apply_list_op(list_cmd_t c);
    list_rsp_t r;
    r = '0;
    case (c.op)
      OP_ADD_FRONT: r.accepted = list_insert(0, c.val);
      OP_ADD_BACK:  r.accepted = list_insert(list_len, c.val);
      OP_INSERT_AT: r.accepted = list_insert(int'(c.pos), c.val);
      OP_REM_FRONT: r.accepted = list_remove(0);
      OP_REM_BACK:  r.accepted = (list_len > 0) ? list_remove(list_len - 1) : 1'b0;
      OP_REM_AT:    r.accepted = list_remove(int'(c.pos));
      OP_READ_AT: begin
        if (int'(c.pos) < list_len) begin
          r.accepted   = 1'b1;
          r.read_value = list_mem[c.pos];
        end
      end
      default: ;  // unused code: list untouched
    endcase
    r.count = list_len[4:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus store and shared bookkeeping
  // --------------------------------------------------------------------------
  pend_word_t pend_q[$];
  list_rsp_t  rsp_due_q[$];     // results owed by the block, oldest first
  int         n_sent   = 0;     // driver side only
  int         n_rcvd   = 0;     // written by the monitor with <=
  int         n_errors = 0;
  int         gen_len  = 0;     // list length as the generator sees it
  int         tx_quiet = 0;     // words left in a no-gap stretch
  int         rx_quiet = 0;
  int         cyc      = 0;

  // Mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Queue one word; ok tells whether the list would act on it
  task automatic push_cmd(input logic [2:0] op, input logic [4:0] pos,
                          input logic [31:0] val, input bit drain, output bit ok);
    pend_word_t w;
    w.cmd   = '{op: op, pos: pos, val: val};
    w.drain = drain;
    if (tx_quiet > 0) begin
      tx_quiet--;
      w.gap = 0;
    end else begin
      w.gap = idle_len();
      if ($urandom_range(0, 49) == 0) tx_quiet = $urandom_range(20, 80);
    end
    ok = 1'b0;
    case (op)
      OP_ADD_FRONT, OP_ADD_BACK: ok = (gen_len < LIST_DEPTH);
      OP_INSERT_AT:              ok = (gen_len < LIST_DEPTH) && (int'(pos) <= gen_len);
      OP_REM_FRONT, OP_REM_BACK: ok = (gen_len > 0);
      OP_REM_AT, OP_READ_AT:     ok = (int'(pos) < gen_len);
      default:                   ok = 1'b0;
    endcase
    if (ok) begin
      if (op == OP_ADD_FRONT || op == OP_ADD_BACK || op == OP_INSERT_AT) gen_len++;
      else if (op != OP_READ_AT) gen_len--;
    end
    pend_q.push_back(w);
  endtask

  function automatic logic [2:0] pick_op(phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_GROW: begin
        if (r < 40) return OP_INSERT_AT;
        if (r < 60) return OP_ADD_FRONT;
        if (r < 80) return OP_ADD_BACK;
        if (r < 90) return OP_READ_AT;
        return OP_REM_AT;
      end
      PH_SHRINK: begin
        if (r < 40) return OP_REM_AT;
        if (r < 60) return OP_REM_FRONT;
        if (r < 80) return OP_REM_BACK;
        if (r < 90) return OP_READ_AT;
        return OP_INSERT_AT;
      end
      default: begin
        if (r < 50) return OP_READ_AT;
        return 3'($urandom_range(0, 6));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting: first ten in full, the rest counted
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    n_errors++;
    if (n_errors <= 10)
      $display("mismatch on result %0d: %s expected %h got %h", n_rcvd, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers pending words, predicts each one as it is taken
  // --------------------------------------------------------------------------
  list_cmd_t  cur_cmd = '0;

  always @(posedge clk) begin
    logic       nxt_valid;
    bit         took;
    pend_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt_valid = in_tvalid;
      took      = in_tvalid && in_tready;
      if (took) begin
        rsp_due_q.push_back(apply_list_op(cur_cmd));
        n_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pend_q.size() > 0) begin
        if (pend_q[0].gap > 0) begin
          pend_q[0].gap--;
        end else if (!pend_q[0].drain || (!took && n_sent == n_rcvd)) begin
          // a drain word waits until the result queue has run dry
          w         = pend_q.pop_front();
          cur_cmd   = w.cmd;
          in_tdata  <= {w.cmd.val, w.cmd.pos, w.cmd.op};
          nxt_valid = 1'b1;
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, checks each result word against the oldest
  // prediction
  // --------------------------------------------------------------------------
  int rx_stall = 0;

  always @(posedge clk) begin
    list_rsp_t got;
    list_rsp_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.accepted   = out_tdata[0];
        got.read_value = out_tdata[32:1];
        got.count      = out_tdata[37:33];
        if (rsp_due_q.size() == 0) begin
          note_mismatch("unexpected word, out_tdata[31:0]", '0, out_tdata[31:0]);
        end else begin
          want = rsp_due_q.pop_front();
          if (got.accepted !== want.accepted)
            note_mismatch("accepted", 32'(want.accepted), 32'(got.accepted));
          if (got.read_value !== want.read_value)
            note_mismatch("read_value", want.read_value, got.read_value);
          if (got.count !== want.count)
            note_mismatch("count", 32'(want.count), 32'(got.count));
        end
        n_rcvd <= n_rcvd + 1;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (rx_quiet > 0) begin
          rx_quiet--;
        end else begin
          if ($urandom_range(0, 2) == 0) rx_stall = idle_len();
          if ($urandom_range(0, 99) == 0) rx_quiet = $urandom_range(30, 120);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYC_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus build, reset, end of run
  // --------------------------------------------------------------------------
  initial begin
    bit         ok;
    int         n_words;
    int         n_total;
    int         ph_left;
    phase_t     ph;
    logic [2:0] op;
    logic [4:0] pos;

    // directed: empty list first
    push_cmd(OP_READ_AT,   5'd0,  32'h0,         1'b0, ok);
    push_cmd(OP_REM_FRONT, 5'd0,  32'h0,         1'b0, ok);
    push_cmd(OP_REM_BACK,  5'd0,  32'h0,         1'b0, ok);
    push_cmd(OP_REM_AT,    5'd0,  32'h0,         1'b0, ok);
    push_cmd(OP_INSERT_AT, 5'd1,  32'h1234_5678, 1'b0, ok);  // past the tail
    push_cmd(OP_INSERT_AT, 5'd0,  32'h8000_0000, 1'b0, ok);
    push_cmd(OP_ADD_BACK,  5'd31, 32'h7fff_ffff, 1'b0, ok);
    push_cmd(OP_ADD_FRONT, 5'd0,  32'hffff_ffff, 1'b0, ok);
    push_cmd(OP_ADD_BACK,  5'd0,  32'h0000_0000, 1'b0, ok);
    push_cmd(OP_INSERT_AT, 5'd4,  32'h5555_5555, 1'b0, ok);  // at the tail: append
    push_cmd(OP_INSERT_AT, 5'd2,  32'haaaa_aaaa, 1'b0, ok);
    for (int i = 0; i <= 6; i++)
      push_cmd(OP_READ_AT, 5'(i), 32'hffff_ffff, 1'b0, ok);  // last one past the tail
    push_cmd(OP_READ_AT,   5'd31, 32'h0,         1'b0, ok);
    push_cmd(OP_UNUSED,    5'd31, 32'hffff_ffff, 1'b0, ok);
    push_cmd(OP_REM_AT,    5'd31, 32'h0,         1'b0, ok);
    push_cmd(OP_INSERT_AT, 5'd31, 32'h0f0f_0f0f, 1'b0, ok);
    push_cmd(OP_REM_AT,    5'd2,  32'h0,         1'b0, ok);
    push_cmd(OP_REM_BACK,  5'd0,  32'h0,         1'b0, ok);
    push_cmd(OP_REM_FRONT, 5'd0,  32'h0,         1'b0, ok);

    // random: phased, mostly well-formed positions, some noise
    n_words = 0;
    ph_left = 0;
    ph      = PH_GROW;
    while (n_words < N_WORDS) begin
      if (ph_left == 0) begin
        ph      = phase_t'($urandom_range(0, 2));
        ph_left = $urandom_range(20, 60);
      end
      ph_left--;
      if ($urandom_range(0, 99) < 12) begin
        op  = 3'($urandom_range(0, 7));
        pos = 5'($urandom_range(0, 31));
      end else begin
        op = pick_op(ph);
        if (op == OP_INSERT_AT) pos = 5'($urandom_range(0, gen_len));
        else if (gen_len > 0)   pos = 5'($urandom_range(0, gen_len - 1));
        else                    pos = 5'd0;
      end
      // hold the sender until everything is back, at the start and every 300 words
      push_cmd(op, pos, pick_value(), (n_words % 300) == 0, ok);
      n_words++;
    end
    n_total = pend_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // every queued word must come back as a result
    while (n_rcvd != n_total) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (n_errors == 0 && rsp_due_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
